### hw/rtl/gllg_pkg.sv
// Shared types, constants and a helper function of the load-level governor.
package gllg_pkg;

    // Default depth of the busy-time history.
    parameter int HISTORY_LEN_DEF = 10;

    // Field widths.
    parameter int BUSY_W   = 32;
    parameter int WIN_W    = 16;
    parameter int PCT_W    = 7;
    parameter int LVLCNT_W = 4;
    parameter int LEVEL_W  = 3;
    parameter int MS_W     = 23;
    parameter int THR_W    = 8;
    parameter int CNT_W    = 5;
    parameter int DIVR_W   = 10;
    parameter int CFG_IDX_W = 2;

    // Shared divider: bits resolved per cycle and cycles per division.
    parameter int DIV_BITS   = 4;
    parameter int DIV_CYCLES = BUSY_W / DIV_BITS;

    // Algorithm constants.
    parameter logic [BUSY_W-1:0]  AVG_IDLE_LIMIT = 32'd4000;
    parameter int                 PCT_SCALE      = 100;
    parameter logic [DIVR_W-1:0]  US_PER_MS      = 10'd1000;
    parameter logic signed [CNT_W-1:0] IDLE_CNT_MAX  = 5'sd10;
    parameter logic signed [CNT_W-1:0] IDLE_CNT_DOWN = 5'sd2;
    parameter logic [LEVEL_W-1:0] LEVEL_RESET    = 3'd3;
    parameter logic [LEVEL_W-1:0] LEVEL_IDLE     = 3'd3;
    parameter logic [LEVEL_W-1:0] LEVEL_MAX      = 3'd7;

    // Configuration register indexes.
    parameter logic [CFG_IDX_W-1:0] CFG_UP_PERCENT   = 2'd0;
    parameter logic [CFG_IDX_W-1:0] CFG_DOWN_PERCENT = 2'd1;
    parameter logic [CFG_IDX_W-1:0] CFG_UP_MARGIN    = 2'd2;
    parameter logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT  = 2'd3;

    // Configuration reset values.
    parameter logic [PCT_W-1:0]    UP_PERCENT_RST   = 7'd60;
    parameter logic [PCT_W-1:0]    DOWN_PERCENT_RST = 7'd25;
    parameter logic [PCT_W-1:0]    UP_MARGIN_RST    = 7'd10;
    parameter logic [LVLCNT_W-1:0] LEVEL_COUNT_RST  = 4'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HIST,
        S_DIV_AVG,
        S_ACC,
        S_DIV_MS,
        S_MUL,
        S_CMP,
        S_DONE
    } t_state;

    // Quotient of a 7-bit value by a small level number (2..7), restoring form.
    function automatic logic [PCT_W-1:0] div_small(input logic [PCT_W-1:0] num,
                                                   input logic [LEVEL_W-1:0] den);
        logic [LEVEL_W-1:0] rem;
        logic [LEVEL_W:0]   rw;
        logic [PCT_W-1:0]   q;
        rem = '0;
        q   = '0;
        for (int i = PCT_W - 1; i >= 0; i--) begin
            rw = {rem, num[i]};
            if (rw >= {1'b0, den}) begin
                rem  = LEVEL_W'(rw - {1'b0, den});
                q[i] = 1'b1;
            end else begin
                rem = rw[LEVEL_W-1:0];
            end
        end
        return q;
    endfunction

endpackage

### hw/rtl/gpu_load_level_governor.sv
// Load-driven power-level governor with a memory-held busy-time history.
//
// Usage: events enter on the s_axis channel (tuser = command, 0 idle event,
// 1 sleep event); one result word leaves on the m_axis channel per event.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_wdata while
// no event is in flight; a write takes effect at the next clock edge.
// Steps per event: idle events do the history update and average division
// if history_tick is set, accumulation, then millisecond division, multiply
// and compare if sample_tick is set; sleep events do multiply and compare.
// The shared divider resolves 4 quotient bits per cycle and runs once for the
// history average and once for busy milliseconds.
// One event is processed at a time; s_axis_tready is high while the block
// waits for an event, even if the previous result still sits in the output
// register. A stalled receiver holds the result there and the block waits in
// its final step until the register is free.
// Reset (synchronous, active low) restores the configuration defaults, level
// 3, a zero history (per-entry valid bits) and an empty output register.
module gpu_load_level_governor #(
    parameter int HISTORY_LEN = gllg_pkg::HISTORY_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port.
    input  logic                          i_cfg_we,
    input  logic [gllg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gllg_pkg::PCT_W-1:0]    i_cfg_wdata,
    // Event input.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata: busy_us[31:0], history_tick[32], sample_tick[33],
    //        window_ms[49:34], touch_active[50], zero fill[55:51]
    input  logic [55:0]                   s_axis_tdata,
    // tuser: command[0]
    input  logic                          s_axis_tuser,
    // Result output.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata: power_level[2:0], level_changed[3], idle_flag[4], touch_boost[5],
    //        average_busy_us[37:6], zero fill[39:38]
    output logic [39:0]                   m_axis_tdata
);
    import gllg_pkg::*;

    localparam int SLOT_W = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;

    // Configuration registers.
    logic [PCT_W-1:0]    r_up_pct;
    logic [PCT_W-1:0]    r_down_pct;
    logic [PCT_W-1:0]    r_up_margin;
    logic [LVLCNT_W-1:0] r_level_count;

    // Control and governor state.
    t_state                  r_state, n_state;
    logic [SLOT_W-1:0]       r_slot;
    logic [BUSY_W-1:0]       r_sum;
    logic [BUSY_W-1:0]       r_avg;
    logic [BUSY_W-1:0]       r_accum;
    logic signed [CNT_W-1:0] r_idle_cnt;
    logic                    r_idle_state;
    logic [LEVEL_W-1:0]      r_level;
    logic [MS_W-1:0]         r_last_ms;
    logic [WIN_W-1:0]        r_last_win;
    logic                    r_out_valid;
    logic [DIV_CYCLES > 1 ? $clog2(DIV_CYCLES)-1 : 0 : 0] r_div_cnt;

    // Latched event fields and working registers.
    logic                    r_sleep;
    logic [BUSY_W-1:0]       r_busy;
    logic                    r_hist_tick;
    logic                    r_samp_tick;
    logic [WIN_W-1:0]        r_window;
    logic                    r_touch;
    logic [LEVEL_W-1:0]      r_before;
    logic                    r_boost;
    logic [THR_W-1:0]        r_thr;
    logic [29:0]             r_load;
    logic [23:0]             r_up_lim;
    logic [22:0]             r_down_lim;
    logic [DIVR_W-1:0]       r_divisor;
    logic [DIVR_W-1:0]       r_rem;
    logic [BUSY_W-1:0]       r_dq;
    logic [39:0]             r_out_data;

    // History memory.
    logic [BUSY_W-1:0]       r_hist [HISTORY_LEN];
    logic [HISTORY_LEN-1:0]  r_hist_vld;
    logic [BUSY_W-1:0]       r_rd_data;
    logic                    r_rd_vld;

    // Combinational signals.
    logic                    c_in_acc;
    logic                    c_out_load;
    logic                    c_div_last;
    logic                    c_mem_we;
    logic [BUSY_W-1:0]       c_old;
    logic [BUSY_W-1:0]       c_new_sum;
    logic [DIVR_W-1:0]       c_rem;
    logic [BUSY_W-1:0]       c_dq;
    logic [DIVR_W:0]         c_rw;
    logic signed [CNT_W-1:0] c_cnt;
    logic                    c_idle_next;
    logic                    c_boost;
    logic [LVLCNT_W-1:0]     c_lvl_ext;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tuser) begin
                        n_state = S_MUL;
                    end else if (s_axis_tdata[32]) begin
                        n_state = S_HIST;
                    end else begin
                        n_state = S_ACC;
                    end
                end
            end
            S_HIST:    n_state = S_DIV_AVG;
            S_DIV_AVG: if (c_div_last) n_state = S_ACC;
            S_ACC:     n_state = r_samp_tick ? S_DIV_MS : S_DONE;
            S_DIV_MS:  if (c_div_last) n_state = S_MUL;
            S_MUL:     n_state = S_CMP;
            S_CMP:     n_state = S_DONE;
            S_DONE:    if (!r_out_valid || m_axis_tready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        c_mem_we      = (r_state == S_HIST);
        c_div_last    = ((r_state == S_DIV_AVG) || (r_state == S_DIV_MS)) &&
                        (r_div_cnt == $bits(r_div_cnt)'(DIV_CYCLES - 1));
        c_out_load    = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);
    end
    assign c_in_acc = s_axis_tvalid && s_axis_tready;

    // History update arithmetic; an entry never written reads as zero.
    assign c_old     = r_rd_vld ? r_rd_data : '0;
    assign c_new_sum = r_sum - c_old + r_accum;

    // One cycle of the restoring divider: DIV_BITS quotient bits.
    always_comb begin
        c_rem = r_rem;
        c_dq  = r_dq;
        c_rw  = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            c_rw = {c_rem, c_dq[BUSY_W-1]};
            c_dq = {c_dq[BUSY_W-2:0], 1'b0};
            if (c_rw >= {1'b0, r_divisor}) begin
                c_rem   = DIVR_W'(c_rw - {1'b0, r_divisor});
                c_dq[0] = 1'b1;
            end else begin
                c_rem = c_rw[DIVR_W-1:0];
            end
        end
    end

    // Idle counter with hysteresis, evaluated on the new average.
    always_comb begin
        c_cnt = r_idle_cnt;
        if ((r_level == LEVEL_IDLE) && (c_dq < AVG_IDLE_LIMIT)) begin
            if (r_idle_cnt < IDLE_CNT_MAX) c_cnt = r_idle_cnt + 5'sd1;
        end else if (r_idle_cnt > 5'sd0) begin
            c_cnt = r_idle_cnt - IDLE_CNT_DOWN;
        end
        c_idle_next = r_idle_state;
        c_boost     = 1'b0;
        if (c_cnt >= IDLE_CNT_MAX) begin
            c_idle_next = 1'b1;
        end else if (c_cnt <= 5'sd0) begin
            c_boost     = r_idle_state && r_touch;
            c_idle_next = 1'b0;
        end
    end

    assign c_lvl_ext = {1'b0, r_level};

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_pct      <= UP_PERCENT_RST;
            r_down_pct    <= DOWN_PERCENT_RST;
            r_up_margin   <= UP_MARGIN_RST;
            r_level_count <= LEVEL_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_UP_PERCENT:   r_up_pct      <= i_cfg_wdata;
                CFG_DOWN_PERCENT: r_down_pct    <= i_cfg_wdata;
                CFG_UP_MARGIN:    r_up_margin   <= i_cfg_wdata;
                CFG_LEVEL_COUNT:  r_level_count <= i_cfg_wdata[LVLCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // History memory: one write port and one registered read port at the slot.
    always_ff @(posedge i_clk) begin
        if (c_mem_we) r_hist[r_slot] <= r_accum;
        r_rd_data <= r_hist[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_vld <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (c_mem_we) r_hist_vld[r_slot] <= 1'b1;
            r_rd_vld <= r_hist_vld[r_slot];
        end
    end

    // Sequencer and governor state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slot       <= '0;
            r_sum        <= '0;
            r_avg        <= '0;
            r_accum      <= '0;
            r_idle_cnt   <= '0;
            r_idle_state <= 1'b0;
            r_level      <= LEVEL_RESET;
            r_last_ms    <= '0;
            r_last_win   <= '0;
            r_div_cnt    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_HIST: begin
                    r_sum  <= c_new_sum;
                    r_slot <= (r_slot == SLOT_W'(HISTORY_LEN - 1)) ? '0 : r_slot + 1'b1;
                end
                S_DIV_AVG: begin
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (c_div_last) begin
                        r_div_cnt    <= '0;
                        r_avg        <= c_dq;
                        r_idle_cnt   <= c_cnt;
                        r_idle_state <= c_idle_next;
                    end
                end
                S_ACC: begin
                    r_accum <= r_accum + r_busy;
                end
                S_DIV_MS: begin
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (c_div_last) begin
                        r_div_cnt  <= '0;
                        r_last_ms  <= c_dq[MS_W-1:0];
                        r_last_win <= r_window;
                    end
                end
                S_CMP: begin
                    r_accum <= '0;
                    if (r_sleep) begin
                        r_idle_state <= 1'b1;
                        r_idle_cnt   <= IDLE_CNT_MAX;
                        if (r_load < 30'(r_down_lim)) r_level <= LEVEL_IDLE;
                    end else if (r_load > 30'(r_up_lim)) begin
                        if ((r_level != '0) && (c_lvl_ext < r_level_count)) begin
                            r_level <= r_level - 1'b1;
                        end
                    end else if (r_load < 30'(r_down_lim)) begin
                        if (((c_lvl_ext + 4'd1) < r_level_count) && (r_level != LEVEL_MAX)) begin
                            r_level <= r_level + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            if (c_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (c_in_acc) begin
            r_sleep     <= s_axis_tuser;
            r_busy      <= s_axis_tdata[31:0];
            r_hist_tick <= s_axis_tdata[32];
            r_samp_tick <= s_axis_tdata[33];
            r_window    <= s_axis_tdata[49:34];
            r_touch     <= s_axis_tdata[50];
            r_before    <= r_level;
            r_boost     <= 1'b0;
        end
        case (r_state)
            S_HIST: begin
                r_divisor <= DIVR_W'(HISTORY_LEN);
                r_rem     <= '0;
                r_dq      <= c_new_sum;
            end
            S_DIV_AVG: begin
                r_rem <= c_rem;
                r_dq  <= c_dq;
                if (c_div_last) r_boost <= c_boost;
            end
            S_ACC: begin
                r_divisor <= US_PER_MS;
                r_rem     <= '0;
                r_dq      <= r_accum + r_busy;
                if (r_level > 3'd1) begin
                    r_thr <= THR_W'(div_small(r_up_pct, r_level)) + THR_W'(r_up_margin);
                end else if (r_up_pct > r_up_margin) begin
                    r_thr <= THR_W'(r_up_pct - r_up_margin);
                end else begin
                    r_thr <= '0;
                end
            end
            S_DIV_MS: begin
                r_rem <= c_rem;
                r_dq  <= c_dq;
            end
            S_MUL: begin
                r_load     <= 30'(r_last_ms) * 30'(PCT_SCALE);
                r_up_lim   <= 24'(r_last_win) * 24'(r_thr);
                r_down_lim <= 23'(r_last_win) * 23'(r_down_pct);
            end
            default: ;
        endcase
        if (c_out_load) begin
            r_out_data <= {2'b00, r_avg, r_boost, r_idle_state,
                           (r_level != r_before), r_level};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // The history slot always addresses a real entry.
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_slot} < (SLOT_W + 1)'(HISTORY_LEN))
        else $error("history slot out of range");

    // The idle counter stays within its hysteresis band.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idle_cnt >= -5'sd1) && (r_idle_cnt <= IDLE_CNT_MAX))
        else $error("idle counter out of range");

    // An accepted word always starts processing.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_in_acc |=> (r_state != S_IDLE))
        else $error("accepted word did not start processing");

    // A sleep word forces the idle state and clears the accumulated busy time.
    a_sleep_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) && r_sleep |=>
            r_idle_state && (r_idle_cnt == IDLE_CNT_MAX) && (r_accum == '0))
        else $error("sleep word did not force idle");

    // The divider step counter runs only while a division is in progress.
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DIV_AVG) && (r_state != S_DIV_MS) |-> (r_div_cnt == '0))
        else $error("divider counter active outside a division");

endmodule
